### sv/idxd_pkg.sv
// ----------------------------------------------------------------------------
// idxd_pkg: shared types and helpers of the IDX stream deframer
// Item structs, result and error codes, the parser phase type and the
// type-byte decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package idxd_pkg;

  // Result queue geometry. The depth must be a power of two and at least 2.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Byte positions inside the header and inside one dimension word.
  localparam logic [2:0] HDR_TYPE_IDX  = 3'd2;
  localparam logic [2:0] DIM_LAST_IDX  = 3'd3;

  typedef enum logic [1:0] {
    KIND_DIM   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    TY_U8  = 3'd0,
    TY_I8  = 3'd1,
    TY_I16 = 3'd2,
    TY_I32 = 3'd3,
    TY_F32 = 3'd4,
    TY_F64 = 3'd5
  } elem_type_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_MAGIC   = 3'd1,
    ERR_ZERO_DIMS   = 3'd2,
    ERR_SHORT_SIZES = 3'd3,
    ERR_SHORT_DATA  = 3'd4
  } err_e;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_DIMS   = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_ERROR  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       byte_present;
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    elem_type_e  elem_type;
    err_e        error_code;
    logic        last;
  } out_item_t;

  // Up to two results are pushed for one input item; vld1 implies vld0.
  typedef struct packed {
    logic      vld0;
    logic      vld1;
    out_item_t item0;
    out_item_t item1;
  } res_push_t;

  function automatic logic type_known(input logic [7:0] b);
    return b inside {8'h08, 8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h0E};
  endfunction

  function automatic elem_type_e decode_type(input logic [7:0] b);
    elem_type_e t;
    case (b)
      8'h09:   t = TY_I8;
      8'h0B:   t = TY_I16;
      8'h0C:   t = TY_I32;
      8'h0D:   t = TY_F32;
      8'h0E:   t = TY_F64;
      default: t = TY_U8;
    endcase
    return t;
  endfunction

  // Index of the final byte of one data item of the given type.
  function automatic logic [2:0] item_last_idx(input elem_type_e t);
    logic [2:0] idx;
    case (t)
      TY_I16:         idx = 3'd1;
      TY_I32, TY_F32: idx = 3'd3;
      TY_F64:         idx = 3'd7;
      default:        idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

### sv/idxd_res_fifo.sv
// ----------------------------------------------------------------------------
// idxd_res_fifo: result queue of the IDX stream deframer
// Takes up to two result items per cycle and hands out one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idxd_res_fifo import idxd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      room2_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  out_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic [FIFO_CW-1:0] push_n;
  logic               pop;

  assign push_n      = FIFO_CW'(push_i.vld0) + FIFO_CW'(push_i.vld1);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room2_o     = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign out_item_o  = mem_q[rd_ptr_q];
  assign count_d     = count_q + push_n - FIFO_CW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n[FIFO_AW-1:0];
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_ptr_q] <= push_i.item0;
    end
    if (push_i.vld1) begin
      mem_q[wr_ptr_q + FIFO_AW'(1)] <= push_i.item1;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld1 |-> push_i.vld0)
    else $error("second result pushed without a first");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld0 |-> room2_o)
    else $error("result pushed without two free entries");
`endif

endmodule

### sv/idx_stream_deframer_core.sv
// ----------------------------------------------------------------------------
// idx_stream_deframer_core: byte-serial IDX file parser, top level
// A result is written into the registered result queue when its byte is accepted; an
// end-of-file report that follows another result of the same byte is queued behind it.
// Throughput: one byte per cycle; after each dimension size the input stalls while the
// 64x32 saturating item-count product runs as two 32x32 partials, and it also stalls
// while the result queue has fewer than two free entries.
// Reset: asynchronous, clears the parser state and the result queue at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idx_stream_deframer_core import idxd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Parser state. The byte counter walks the header, each dimension word and
  // each data item; the accumulator gathers big-endian words.
  phase_e      phase_q, phase_d;
  logic [2:0]  biw_q, biw_d;
  elem_type_e  type_q, type_d;
  logic [7:0]  dims_left_q, dims_left_d;
  logic [63:0] accum_q, accum_d;
  logic [63:0] items_left_q, items_left_d;

  // Item-count multiplier. The operands are captured when a dimension word
  // completes; the low partial product is registered while mul_s1_q is set and
  // the high partial with the saturation check is formed while mul_s2_q is set.
  logic        mul_s1_q, mul_s2_q;
  logic        mul_busy;
  logic        mul_start;
  logic [63:0] opa_q;
  logic [31:0] opb_q;
  logic [63:0] p0_q, p0_d;
  logic [63:0] p1;
  logic [64:0] hi_sum;
  logic [63:0] mul_res;

  logic        accept;
  logic        room2;
  logic [63:0] accum_sh;
  logic [31:0] dim_word;
  logic [7:0]  dims_dec;
  logic        zero_prod;
  logic        fin;
  logic        step_vld, eof_vld;
  out_item_t   step_res, eof_res;
  res_push_t   push;

  assign mul_busy = mul_s1_q | mul_s2_q;

  // The input waits while the item count is being updated, and whenever the
  // queue could not take the two results a single byte may cause.
  assign in_stall_o = mul_busy || !room2;
  assign accept     = in_valid_i && !in_stall_o;

  assign accum_sh  = {accum_q[55:0], in_item_i.data_byte};
  assign dim_word  = accum_sh[31:0];
  assign dims_dec  = dims_left_q - 8'd1;
  // The saturated product is zero exactly when one factor is zero, so the
  // final flag of a dimension result needs no multiplier.
  assign zero_prod = (items_left_q == '0) || (dim_word == '0);

  always_comb begin
    phase_d     = phase_q;
    biw_d       = biw_q;
    type_d      = type_q;
    dims_left_d = dims_left_q;
    accum_d     = accum_q;
    items_left_d = items_left_q;
    mul_start   = 1'b0;
    fin         = 1'b0;
    step_vld    = 1'b0;
    eof_vld     = 1'b0;
    step_res    = '{kind: KIND_ERROR, value: '0, elem_type: TY_U8,
                    error_code: ERR_BAD_MAGIC, last: 1'b1};
    eof_res     = '{kind: KIND_ERROR, value: '0, elem_type: TY_U8,
                    error_code: ERR_BAD_MAGIC, last: 1'b1};

    if (accept && in_item_i.byte_present) begin
      case (phase_q)
        PH_HEADER: begin
          if (biw_q < HDR_TYPE_IDX) begin
            // Magic bytes must be zero.
            if (in_item_i.data_byte != 8'd0) begin
              step_vld = 1'b1;
              phase_d  = PH_ERROR;
            end else begin
              biw_d = biw_q + 3'd1;
            end
          end else if (biw_q == HDR_TYPE_IDX) begin
            if (!type_known(in_item_i.data_byte)) begin
              step_vld = 1'b1;
              phase_d  = PH_ERROR;
            end else begin
              type_d = decode_type(in_item_i.data_byte);
              biw_d  = biw_q + 3'd1;
            end
          end else begin
            // Dimension count: zero is rejected.
            if (in_item_i.data_byte == 8'd0) begin
              step_vld            = 1'b1;
              step_res.error_code = ERR_ZERO_DIMS;
              phase_d             = PH_ERROR;
            end else begin
              dims_left_d  = in_item_i.data_byte;
              phase_d      = PH_DIMS;
              biw_d        = '0;
              accum_d      = '0;
              items_left_d = 64'd1;
            end
          end
        end
        PH_DIMS: begin
          accum_d = accum_sh;
          if (biw_q == DIM_LAST_IDX) begin
            fin       = (dims_dec == 8'd0) && zero_prod;
            step_vld  = 1'b1;
            step_res  = '{kind: KIND_DIM, value: {32'd0, dim_word}, elem_type: type_q,
                          error_code: ERR_NONE, last: fin};
            mul_start   = 1'b1;
            dims_left_d = dims_dec;
            biw_d       = '0;
            accum_d     = '0;
            if (dims_dec == 8'd0) begin
              phase_d = fin ? PH_DONE : PH_DATA;
            end
          end else begin
            biw_d = biw_q + 3'd1;
          end
        end
        PH_DATA: begin
          accum_d = accum_sh;
          if (biw_q == item_last_idx(type_q)) begin
            fin          = (items_left_q == 64'd1);
            items_left_d = items_left_q - 64'd1;
            step_vld     = 1'b1;
            step_res     = '{kind: KIND_DATA, value: accum_sh, elem_type: type_q,
                             error_code: ERR_NONE, last: fin};
            biw_d        = '0;
            accum_d      = '0;
            if (fin) begin
              phase_d = PH_DONE;
            end
          end else begin
            biw_d = biw_q + 3'd1;
          end
        end
        default: begin
          // Finished or failed file: bytes are dropped until end of file.
        end
      endcase
    end

    // End of file reports whatever part is still open after this byte, then
    // rearms the parser. A pending count update is dropped with it.
    if (accept && in_item_i.end_of_file) begin
      case (phase_d)
        PH_HEADER: begin
          eof_vld = 1'b1;
        end
        PH_DIMS: begin
          eof_vld            = 1'b1;
          eof_res.error_code = ERR_SHORT_SIZES;
        end
        PH_DATA: begin
          eof_vld            = 1'b1;
          eof_res.error_code = ERR_SHORT_DATA;
        end
        default: begin
        end
      endcase
      phase_d      = PH_HEADER;
      biw_d        = '0;
      type_d       = TY_U8;
      dims_left_d  = '0;
      accum_d      = '0;
      items_left_d = 64'd1;
      mul_start    = 1'b0;
    end
  end

  // Results are packed so that the first queue slot is always used first.
  assign push.vld0  = step_vld | eof_vld;
  assign push.vld1  = step_vld & eof_vld;
  assign push.item0 = step_vld ? step_res : eof_res;
  assign push.item1 = eof_res;

  // Saturating product: overflow shows as any bit at position 64 or higher of the full product.
  assign p0_d    = 64'(opa_q[31:0]) * 64'(opb_q);
  assign p1      = 64'(opa_q[63:32]) * 64'(opb_q);
  assign hi_sum  = {1'b0, p1} + {33'd0, p0_q[63:32]};
  assign mul_res = (hi_sum[64:32] != '0) ? '1 : {hi_sum[31:0], p0_q[31:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      biw_q        <= '0;
      type_q       <= TY_U8;
      dims_left_q  <= '0;
      accum_q      <= '0;
      items_left_q <= 64'd1;
      mul_s1_q     <= 1'b0;
      mul_s2_q     <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      biw_q       <= biw_d;
      type_q      <= type_d;
      dims_left_q <= dims_left_d;
      accum_q     <= accum_d;
      mul_s1_q    <= mul_start;
      mul_s2_q    <= mul_s1_q;
      if (mul_s2_q) begin
        items_left_q <= mul_res;
      end else begin
        items_left_q <= items_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      opa_q <= items_left_q;
      opb_q <= dim_word;
    end
    if (mul_s1_q) begin
      p0_q <= p0_d;
    end
  end

  idxd_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |=> in_stall_o ##1 in_stall_o)
    else $error("input accepted during item count update");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.kind == KIND_ERROR)) |-> out_item_o.last)
    else $error("error report without last flag");

  a_data_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_DATA) && !mul_busy) |-> (items_left_q != '0))
    else $error("data phase with zero items left");
`endif

endmodule
